### rtl/core/bft_pkg.sv
`default_nettype none

package bft_pkg;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 40;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_ERASE  = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_PRESENT   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [1:0] DIR_FWD  = 2'd0;
  localparam logic [1:0] DIR_REV  = 2'd1;
  localparam logic [1:0] DIR_NONE = 2'd2;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_INSERT,
    OP_ERASE,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [15:0] dp;
    logic [15:0] sp;
    logic [31:0] da;
    logic [31:0] sa;
  } key_t;

  typedef struct packed {
    op_t  op;
    key_t key;
  } item_t;

  typedef struct packed {
    logic        valid;
    key_t        key;
    logic [31:0] number;
  } entry_t;

endpackage

`default_nettype wire

### rtl/core/bft_front.sv
`default_nettype none

module bft_front
  import bft_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  enable,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
  output logic                       item_valid,
  input  wire logic                  item_ready,
  output item_t                      item
);

  item_t      q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  item_t      dec;
  logic       push;
  logic       pop;

  always_comb begin
    dec.key.sa = s_axis_tdata[33:2];
    dec.key.da = s_axis_tdata[65:34];
    dec.key.sp = s_axis_tdata[81:66];
    dec.key.dp = s_axis_tdata[97:82];
    unique case (s_axis_tdata[1:0])
      CMD_LOOKUP: dec.op = OP_LOOKUP;
      CMD_INSERT: dec.op = OP_INSERT;
      CMD_ERASE:  dec.op = OP_ERASE;
      default:    dec.op = OP_NOP;
    endcase
  end

  assign s_axis_tready = enable && (cnt != 2'd2);
  assign item_valid    = (cnt != 2'd0);
  assign item          = q[rp];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/bft_back.sv
`default_nettype none

module bft_back
  import bft_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  output logic                        ready_en,
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire item_t                  item,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data;

  state_t      state;
  item_t       cur;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] rd_idx;
  logic        issuing;
  logic        rd_vld;
  logic        fwd_hit;
  logic        rev_hit;
  logic        free_hit;
  logic [IW-1:0] fwd_idx;
  logic [IW-1:0] free_idx;
  logic [31:0] fwd_num;
  logic [31:0] rev_num;
  logic [31:0] next_number;

  key_t        rev_key;
  logic        e_fwd;
  logic        e_rev;
  logic        e_free;
  logic        rd_en;
  logic        out_free;
  logic        wr_en;
  logic [IW-1:0] wr_addr;
  entry_t      wr_data;
  logic        do_insert;
  logic [1:0]  res_status;
  logic [1:0]  res_dir;
  logic [31:0] res_id;

  always_comb begin
    rev_key.sa = cur.key.da;
    rev_key.da = cur.key.sa;
    rev_key.sp = cur.key.dp;
    rev_key.dp = cur.key.sp;
  end

  assign e_fwd    = rd_data.valid && (rd_data.key == cur.key);
  assign e_rev    = rd_data.valid && (rd_data.key == rev_key);
  assign e_free   = !rd_data.valid;
  assign rd_en    = (state == S_SCAN) && issuing;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign item_ready = (state == S_IDLE);
  assign ready_en   = (state != S_CLEAR);

  always_comb begin
    res_status = ST_NOT_FOUND;
    res_dir    = DIR_NONE;
    res_id     = 32'd0;
    do_insert  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = rd_addr;
    wr_data    = '0;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (state == S_DECIDE) begin
      unique case (cur.op)
        OP_LOOKUP: begin
          if (fwd_hit) begin
            res_status = ST_DONE;
            res_dir    = DIR_FWD;
            res_id     = fwd_num;
          end else if (rev_hit) begin
            res_status = ST_DONE;
            res_dir    = DIR_REV;
            res_id     = rev_num;
          end
        end
        OP_INSERT: begin
          if (fwd_hit) begin
            res_status = ST_PRESENT;
            res_dir    = DIR_FWD;
            res_id     = fwd_num;
          end else if (rev_hit) begin
            res_status = ST_PRESENT;
            res_dir    = DIR_REV;
            res_id     = rev_num;
          end else if (free_hit) begin
            res_status     = ST_DONE;
            res_dir        = DIR_FWD;
            res_id         = next_number;
            do_insert      = out_free;
            wr_en          = out_free;
            wr_addr        = free_idx;
            wr_data.valid  = 1'b1;
            wr_data.key    = cur.key;
            wr_data.number = next_number;
          end else begin
            res_status = ST_FULL;
          end
        end
        OP_ERASE: begin
          if (fwd_hit) begin
            res_status = ST_DONE;
            res_dir    = DIR_FWD;
            res_id     = fwd_num;
            wr_en      = out_free;
            wr_addr    = fwd_idx;
          end
        end
        OP_NOP: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      rd_addr       <= '0;
      issuing       <= 1'b0;
      rd_vld        <= 1'b0;
      fwd_hit       <= 1'b0;
      rev_hit       <= 1'b0;
      free_hit      <= 1'b0;
      next_number   <= 32'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_DECIDE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (rd_addr == LAST) begin
            rd_addr <= '0;
            state   <= S_IDLE;
          end else begin
            rd_addr <= rd_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            cur      <= item;
            rd_addr  <= '0;
            issuing  <= 1'b1;
            rd_vld   <= 1'b0;
            fwd_hit  <= 1'b0;
            rev_hit  <= 1'b0;
            free_hit <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_vld <= issuing;
          rd_idx <= rd_addr;
          if (issuing) begin
            if (rd_addr == LAST) begin
              issuing <= 1'b0;
            end else begin
              rd_addr <= rd_addr + 1'b1;
            end
          end
          if (rd_vld) begin
            if (e_fwd && !fwd_hit) begin
              fwd_hit <= 1'b1;
              fwd_idx <= rd_idx;
              fwd_num <= rd_data.number;
            end
            if (e_rev && !rev_hit) begin
              rev_hit <= 1'b1;
              rev_num <= rd_data.number;
            end
            if (e_free && !free_hit) begin
              free_hit <= 1'b1;
              free_idx <= rd_idx;
            end
            if (rd_idx == LAST) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {4'b0, res_id, res_dir, res_status};
            if (do_insert) begin
              next_number <= next_number + 32'd1;
            end
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/bidirectional_flow_table.sv
`default_nettype none
// The back end takes one operation at a time and scans the entry memory
// one entry per cycle through its single read port.
// Reset: synchronous; a clearing pass over every entry follows, with
// s_axis_tready low until it completes.

module bidirectional_flow_table
  import bft_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // cmd[1:0], src_addr[33:2], dst_addr[65:34], src_port[81:66], dst_port[97:82]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // status[1:0], direction[3:2], conn_id[35:4]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  logic  ready_en;
  logic  item_valid;
  logic  item_ready;
  item_t item;

  bft_front u_front (
    .clk           (clk),
    .rst           (rst),
    .enable        (ready_en),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item)
  );

  bft_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .ready_en      (ready_en),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef NO_ASSERTIONS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_axis_tready)
    else $error("input accepted during clearing pass");

  a_full_no_match: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1:0] == ST_FULL) |->
      (m_axis_tdata[3:2] == DIR_NONE && m_axis_tdata[35:4] == 32'd0))
    else $error("full status with match fields");

  a_miss_no_match: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1:0] == ST_NOT_FOUND) |->
      (m_axis_tdata[3:2] == DIR_NONE && m_axis_tdata[35:4] == 32'd0))
    else $error("not-found status with match fields");

  a_present_has_dir: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1:0] == ST_PRESENT) |->
      (m_axis_tdata[3:2] == DIR_FWD || m_axis_tdata[3:2] == DIR_REV))
    else $error("present status without direction");
`endif

endmodule

`default_nettype wire
